FILE: rtl/core/tkvs_pkg.sv
// ----------------------------------------------------------------------------
// Top-k variant selector package
// Shared widths, codes, item types and preference/sort compare functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tkvs_pkg;

   localparam int SLOTS_DEF   = 8;
   localparam int WINDOW      = 1024;
   localparam int OFFSET_W    = $clog2(WINDOW);
   localparam int POS_W       = 32;
   localparam int KIND_W      = 2;
   localparam int ALLELE_W    = 4;
   localparam int DEPTH_W     = 16;
   localparam int FREQ_W      = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_START   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREQ_THRESHOLD = 1'b1;

   localparam logic CMD_OFFER    = 1'b0;
   localparam logic CMD_FINALIZE = 1'b1;

   localparam logic [KIND_W-1:0] KIND_SNV  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INS  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEL  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   localparam logic [FREQ_W-1:0] HALF_Q16        = 16'h8000;
   localparam logic [FREQ_W:0]   ONE_Q16         = 17'h10000;
   localparam logic [FREQ_W-1:0] THRESHOLD_RESET = 16'd3277;

   typedef struct packed {
      logic                command;
      logic [OFFSET_W-1:0] offset;
      logic [KIND_W-1:0]   var_type;
      logic [ALLELE_W-1:0] allele;
      logic [DEPTH_W-1:0]  depth;
      logic [FREQ_W-1:0]   allele_freq;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [POS_W-1:0]    ref_position;
      logic [KIND_W-1:0]   kind;
      logic [ALLELE_W-1:0] allele_index;
      logic [DEPTH_W-1:0]  coverage;
      logic [FREQ_W-1:0]   frequency;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]    position;
      logic [KIND_W-1:0]   kind;
      logic [ALLELE_W-1:0] allele;
      logic [DEPTH_W-1:0]  coverage;
      logic [FREQ_W-1:0]   frequency;
   } entry_type;

   typedef struct packed {
      logic sort_mode;
      logic clear_marks;
   } cell_ctl_type;

   function automatic logic [FREQ_W-1:0] deviation(input logic [FREQ_W-1:0] f);
      return (f >= HALF_Q16) ? (f - HALF_Q16) : (HALF_Q16 - f);
   endfunction

   // True if entry a is strictly less preferred than entry b.
   function automatic logic worse(input entry_type a, input entry_type b);
      logic [FREQ_W-1:0] da;
      logic [FREQ_W-1:0] db;
      da = deviation(a.frequency);
      db = deviation(b.frequency);
      if (da == db) begin
         return a.coverage < b.coverage;
      end
      return da > db;
   endfunction

   // True if entry a sorts strictly ahead of entry b on position, kind, allele.
   function automatic logic sorts_ahead(input entry_type a, input entry_type b);
      return {a.position, a.kind, a.allele} < {b.position, b.kind, b.allele};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tkvs_cell.sv
// ----------------------------------------------------------------------------
// Top-k variant selector cell
// Holds one slot and passes the running worst or lowest-key entry onward.
// ----------------------------------------------------------------------------
`default_nettype none

module tkvs_cell #(
   parameter int IDX_W    = 3,
   parameter int CELL_IDX = 0
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire tkvs_pkg::cell_ctl_type  ctl,
   input  wire                          live,
   input  wire                          wr_en,
   input  wire tkvs_pkg::entry_type     wr_entry,
   input  wire                          mark_en,
   input  wire                          in_valid,
   input  wire [IDX_W-1:0]              in_idx,
   input  wire tkvs_pkg::entry_type     in_entry,
   output logic                         out_valid,
   output logic [IDX_W-1:0]             out_idx,
   output tkvs_pkg::entry_type          out_entry
);

   tkvs_pkg::entry_type entry_ff;
   logic                mark_ff;
   logic                mark_in;
   logic                eligible;
   logic                take_own;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [IDX_W-1:0]    out_idx_ff;
   logic [IDX_W-1:0]    out_idx_in;
   tkvs_pkg::entry_type out_entry_ff;
   tkvs_pkg::entry_type out_entry_in;

   always_comb begin
      eligible = ctl.sort_mode ? (live && !mark_ff) : live;
      if (!eligible) begin
         take_own = 1'b0;
      end else if (!in_valid) begin
         take_own = 1'b1;
      end else if (ctl.sort_mode) begin
         take_own = tkvs_pkg::sorts_ahead(entry_ff, in_entry);
      end else begin
         take_own = tkvs_pkg::worse(entry_ff, in_entry);
      end
      out_valid_in = take_own || in_valid;
      out_idx_in   = take_own ? IDX_W'(CELL_IDX) : in_idx;
      out_entry_in = take_own ? entry_ff : in_entry;
      if (ctl.clear_marks) begin
         mark_in = 1'b0;
      end else begin
         mark_in = mark_ff || mark_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mark_ff      <= mark_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
      out_idx_ff   <= out_idx_in;
      out_entry_ff <= out_entry_in;
   end

   assign out_valid = out_valid_ff;
   assign out_idx   = out_idx_ff;
   assign out_entry = out_entry_ff;

endmodule

`default_nettype wire

FILE: rtl/core/top_k_variant_selector_top.sv
// ----------------------------------------------------------------------------
// Top-k variant selector
// Keeps the SLOTS most balanced candidates and emits them sorted on finalize.
// ----------------------------------------------------------------------------
// An offer that is filtered out, or that lands while slots are free, is taken without the block leaving idle.
// An offer into a full store scans the cell chain and keeps busy high through the scan and the replace step.
// A finalize with n kept entries gives n items in sort order, one per scan of the cell chain;
// with an empty store the single item follows in the next cycle.
// The chain length SLOTS sets each scan; the receiver cannot stall results.
// Reset empties the store and restores the register defaults; slot contents stay unknown.
`default_nettype none

module top_k_variant_selector_top #(
   parameter int SLOTS = tkvs_pkg::SLOTS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire tkvs_pkg::req_type               req_item,
   output logic                                 rsp_strobe,
   output tkvs_pkg::rsp_type                    rsp_item,
   input  wire                                  csr_we,
   input  wire [tkvs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire [tkvs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int USED_W = $clog2(SLOTS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_USE  = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [IDX_W-1:0]                 cnt_ff, cnt_in;
   logic [IDX_W-1:0]                 emit_ff, emit_in;
   logic [USED_W-1:0]                used_ff, used_in;
   logic                             sort_mode_ff, sort_mode_in;
   tkvs_pkg::entry_type              new_entry_ff, new_entry_in;
   logic [tkvs_pkg::POS_W-1:0]       window_start_ff, window_start_in;
   logic [tkvs_pkg::FREQ_W-1:0]      threshold_ff, threshold_in;
   logic                             rsp_strobe_ff, rsp_strobe_in;
   tkvs_pkg::rsp_type                rsp_item_ff, rsp_item_in;

   logic                             accept;
   logic                             band_ok;
   logic                             offer_ok;
   logic                             full;
   logic                             last_emit;
   tkvs_pkg::entry_type              offer_entry;
   logic                             wr_any;
   logic [IDX_W-1:0]                 wr_idx;
   tkvs_pkg::entry_type              wr_entry;
   logic                             mark_any;
   tkvs_pkg::cell_ctl_type           ctl;

   logic [SLOTS:0]                   chain_valid;
   logic [IDX_W-1:0]                 chain_idx   [0:SLOTS];
   tkvs_pkg::entry_type              chain_entry [0:SLOTS];

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign full       = (used_ff == USED_W'(SLOTS));
   assign last_emit  = ((USED_W'(emit_ff) + USED_W'(1)) == used_ff);

   assign band_ok = (req_item.allele_freq > threshold_ff) &&
                    ({1'b0, req_item.allele_freq} < (tkvs_pkg::ONE_Q16 - {1'b0, threshold_ff}));
   assign offer_ok = band_ok && (req_item.var_type != tkvs_pkg::KIND_NONE);

   assign offer_entry.position  = window_start_ff + tkvs_pkg::POS_W'(req_item.offset);
   assign offer_entry.kind      = req_item.var_type;
   assign offer_entry.allele    = req_item.allele;
   assign offer_entry.coverage  = req_item.depth;
   assign offer_entry.frequency = req_item.allele_freq;

   assign ctl.sort_mode   = sort_mode_ff;
   assign ctl.clear_marks = accept && (req_item.command == tkvs_pkg::CMD_FINALIZE);

   always_comb begin
      window_start_in = window_start_ff;
      threshold_in    = threshold_ff;
      if (csr_we) begin
         case (csr_index)
            tkvs_pkg::CSR_WINDOW_START: begin
               window_start_in = csr_wdata;
            end
            tkvs_pkg::CSR_FREQ_THRESHOLD: begin
               threshold_in = csr_wdata[tkvs_pkg::FREQ_W-1:0];
            end
            default: begin
               window_start_in = window_start_ff;
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      emit_in       = emit_ff;
      used_in       = used_ff;
      sort_mode_in  = sort_mode_ff;
      new_entry_in  = new_entry_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      wr_any        = 1'b0;
      wr_idx        = used_ff[IDX_W-1:0];
      wr_entry      = offer_entry;
      mark_any      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.command == tkvs_pkg::CMD_FINALIZE) begin
                  if (used_ff == '0) begin
                     rsp_strobe_in    = 1'b1;
                     rsp_item_in      = '0;
                     rsp_item_in.last = 1'b1;
                  end else begin
                     sort_mode_in = 1'b1;
                     cnt_in       = '0;
                     emit_in      = '0;
                     state_in     = ST_SCAN;
                  end
               end else if (offer_ok) begin
                  if (full) begin
                     new_entry_in = offer_entry;
                     sort_mode_in = 1'b0;
                     cnt_in       = '0;
                     state_in     = ST_SCAN;
                  end else begin
                     wr_any  = 1'b1;
                     used_in = used_ff + USED_W'(1);
                  end
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff == IDX_W'(SLOTS - 1)) begin
               cnt_in   = '0;
               state_in = ST_USE;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_USE: begin
            if (sort_mode_ff) begin
               rsp_strobe_in            = 1'b1;
               rsp_item_in.found        = 1'b1;
               rsp_item_in.ref_position = chain_entry[SLOTS].position;
               rsp_item_in.kind         = chain_entry[SLOTS].kind;
               rsp_item_in.allele_index = chain_entry[SLOTS].allele;
               rsp_item_in.coverage     = chain_entry[SLOTS].coverage;
               rsp_item_in.frequency    = chain_entry[SLOTS].frequency;
               rsp_item_in.last         = last_emit;
               mark_any                 = 1'b1;
               if (last_emit) begin
                  used_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + IDX_W'(1);
                  state_in = ST_SCAN;
               end
            end else begin
               if (!tkvs_pkg::worse(new_entry_ff, chain_entry[SLOTS])) begin
                  wr_any   = 1'b1;
                  wr_idx   = chain_idx[SLOTS];
                  wr_entry = new_entry_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         emit_ff         <= '0;
         used_ff         <= '0;
         sort_mode_ff    <= 1'b0;
         window_start_ff <= '0;
         threshold_ff    <= tkvs_pkg::THRESHOLD_RESET;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         emit_ff         <= emit_in;
         used_ff         <= used_in;
         sort_mode_ff    <= sort_mode_in;
         window_start_ff <= window_start_in;
         threshold_ff    <= threshold_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      new_entry_ff <= new_entry_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign chain_valid[0] = 1'b0;
   assign chain_idx[0]   = '0;
   assign chain_entry[0] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic live;
      logic wr_en;
      logic mark_en;

      assign live    = (USED_W'(i) < used_ff);
      assign wr_en   = wr_any && (wr_idx == IDX_W'(i));
      assign mark_en = mark_any && (chain_idx[SLOTS] == IDX_W'(i));

      tkvs_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .live      (live),
         .wr_en     (wr_en),
         .wr_entry  (wr_entry),
         .mark_en   (mark_en),
         .in_valid  (chain_valid[i]),
         .in_idx    (chain_idx[i]),
         .in_entry  (chain_entry[i]),
         .out_valid (chain_valid[i+1]),
         .out_idx   (chain_idx[i+1]),
         .out_entry (chain_entry[i+1])
      );
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

`default_nettype wire

FILE: bench/top_k_variant_selector_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k variant selector testbench
// Offers candidate variants and finalize commands through the start/busy
// port and predicts the kept set alongside the block: the band filter, the
// preference order with eviction of the lowest equally worst slot, and the
// sorted emission on finalize. Each emitted item is checked field by field.
// Directed cases cover band edges, ties and window wrap; random traffic runs
// under several register settings with bursts of idle cycles on the input.
// ----------------------------------------------------------------------------

module top_k_variant_selector_top_tb;

   localparam int KEEP          = tkvs_pkg::SLOTS_DEF;
   localparam int SETTLE_CYCLES = KEEP + 4;
   localparam int IDLE_LIMIT    = 2000;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             start;
   logic                             busy;
   tkvs_pkg::req_type                req_item;
   logic                             rsp_strobe;
   tkvs_pkg::rsp_type                rsp_item;
   logic                             csr_we;
   logic [tkvs_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tkvs_pkg::CSR_DATA_W-1:0]  csr_wdata;

   tkvs_pkg::entry_type kept_entries [KEEP];
   int                  kept_count = 0;
   logic [31:0]         window_base = 32'd0;
   logic [15:0]         band_floor = tkvs_pkg::THRESHOLD_RESET;
   tkvs_pkg::rsp_type   due_variants [$];

   int mismatches    = 0;
   int items_sent    = 0;
   int variants_seen = 0;
   int finalize_runs = 0;
   int evictions     = 0;
   int settings_used = 0;
   int idle_cycles   = 0;

   top_k_variant_selector_top #(
      .SLOTS(KEEP)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int distance_from_half(input logic [15:0] freq);
      int value;
      value = int'(freq);
      return (value >= 32768) ? value - 32768 : 32768 - value;
   endfunction

   // True when candidate a is strictly less preferred than candidate b: further from half, or as far with lower depth.
   function automatic bit less_preferred(input logic [15:0] freq_a, input logic [15:0] depth_a,
                                         input logic [15:0] freq_b, input logic [15:0] depth_b);
      int dist_a;
      int dist_b;
      dist_a = distance_from_half(freq_a);
      dist_b = distance_from_half(freq_b);
      if (dist_a == dist_b) begin
         return depth_a < depth_b;
      end
      return dist_a > dist_b;
   endfunction

   function automatic bit ranks_ahead(input tkvs_pkg::entry_type a,
                                      input tkvs_pkg::entry_type b);
      if (a.position != b.position) begin
         return a.position < b.position;
      end
      if (a.kind != b.kind) begin
         return a.kind < b.kind;
      end
      return a.allele < b.allele;
   endfunction

   function automatic void select_variants(input tkvs_pkg::req_type it);
      int                order [KEEP];
      int                i;
      int                j;
      int                slot;
      int                freq;
      tkvs_pkg::rsp_type r;
      if (it.command == tkvs_pkg::CMD_FINALIZE) begin
         finalize_runs++;
         if (kept_count == 0) begin
            r = '0;
            r.last = 1'b1;
            due_variants.push_back(r);
            return;
         end
         for (i = 0; i < kept_count; i++) begin
            j = i;
            while (j > 0 && ranks_ahead(kept_entries[i], kept_entries[order[j-1]])) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = i;
         end
         for (i = 0; i < kept_count; i++) begin
            r.found        = 1'b1;
            r.ref_position = kept_entries[order[i]].position;
            r.kind         = kept_entries[order[i]].kind;
            r.allele_index = kept_entries[order[i]].allele;
            r.coverage     = kept_entries[order[i]].coverage;
            r.frequency    = kept_entries[order[i]].frequency;
            r.last         = (i == kept_count - 1);
            due_variants.push_back(r);
         end
         kept_count = 0;
         return;
      end
      if (it.var_type == tkvs_pkg::KIND_NONE) begin
         return;
      end
      freq = int'(it.allele_freq);
      if (!(freq > int'(band_floor) && freq < 65536 - int'(band_floor))) begin
         return;
      end
      if (kept_count >= KEEP) begin
         slot = 0;
         for (i = 1; i < KEEP; i++) begin
            if (less_preferred(kept_entries[i].frequency, kept_entries[i].coverage,
                               kept_entries[slot].frequency, kept_entries[slot].coverage)) begin
               slot = i;
            end
         end
         if (less_preferred(it.allele_freq, it.depth,
                            kept_entries[slot].frequency, kept_entries[slot].coverage)) begin
            return;
         end
         evictions++;
      end else begin
         slot = kept_count;
         kept_count++;
      end
      kept_entries[slot].position  = window_base + 32'(it.offset);
      kept_entries[slot].kind      = it.var_type;
      kept_entries[slot].allele    = it.allele;
      kept_entries[slot].coverage  = it.depth;
      kept_entries[slot].frequency = it.allele_freq;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                  input logic [31:0] got_v);
      $display("mismatch on %s: expected %0h, got %0h at %0t", what, want_v, got_v, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_variants
      tkvs_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         variants_seen++;
         if (due_variants.size() == 0) begin
            report_mismatch("item with nothing due", 32'd0, rsp_item.ref_position);
         end else begin
            want = due_variants.pop_front();
            if (rsp_item.found !== want.found) begin
               report_mismatch("found", 32'(want.found), 32'(rsp_item.found));
            end
            if (rsp_item.ref_position !== want.ref_position) begin
               report_mismatch("ref_position", want.ref_position, rsp_item.ref_position);
            end
            if (rsp_item.kind !== want.kind) begin
               report_mismatch("kind", 32'(want.kind), 32'(rsp_item.kind));
            end
            if (rsp_item.allele_index !== want.allele_index) begin
               report_mismatch("allele_index", 32'(want.allele_index),
                               32'(rsp_item.allele_index));
            end
            if (rsp_item.coverage !== want.coverage) begin
               report_mismatch("coverage", 32'(want.coverage), 32'(rsp_item.coverage));
            end
            if (rsp_item.frequency !== want.frequency) begin
               report_mismatch("frequency", 32'(want.frequency), 32'(rsp_item.frequency));
            end
            if (rsp_item.last !== want.last) begin
               report_mismatch("last", 32'(want.last), 32'(rsp_item.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timed out with %0d items still due.", due_variants.size());
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input tkvs_pkg::req_type it);
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      select_variants(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic offer(input int offset, input logic [1:0] kind, input int allele,
                        input int depth, input int freq);
      tkvs_pkg::req_type it;
      it.command     = tkvs_pkg::CMD_OFFER;
      it.offset      = 10'(offset);
      it.var_type    = kind;
      it.allele      = 4'(allele);
      it.depth       = 16'(depth);
      it.allele_freq = 16'(freq);
      send_item(it);
   endtask

   task automatic finalize();
      tkvs_pkg::req_type it;
      it         = '0;
      it.command = tkvs_pkg::CMD_FINALIZE;
      send_item(it);
   endtask

   task automatic maybe_pause(input int gap_odds);
      if (gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (due_variants.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] base, input logic [31:0] threshold);
      csr_we    <= 1'b1;
      csr_index <= tkvs_pkg::CSR_WINDOW_START;
      csr_wdata <= base;
      @(negedge clock);
      csr_index <= tkvs_pkg::CSR_FREQ_THRESHOLD;
      csr_wdata <= threshold;
      @(negedge clock);
      csr_we      <= 1'b0;
      window_base = base;
      band_floor  = threshold[15:0];
      settings_used++;
   endtask

   function automatic tkvs_pkg::req_type random_item(input int finalize_odds);
      tkvs_pkg::req_type it;
      it.command     = tkvs_pkg::CMD_OFFER;
      it.offset      = 10'($urandom_range(0, 1023));
      it.var_type    = 2'($urandom_range(0, 2));
      it.allele      = 4'($urandom_range(0, 9));
      it.depth       = 16'($urandom_range(0, 65535));
      it.allele_freq = 16'($urandom_range(0, 65535));
      if ($urandom_range(1, 10) <= 3) begin
         it.offset = 10'($urandom_range(0, 3));
      end
      if ($urandom_range(1, 16) == 1) begin
         it.var_type = tkvs_pkg::KIND_NONE;
      end
      if ($urandom_range(1, 5) == 1) begin
         it.allele = 4'($urandom_range(0, 15));
      end
      if ($urandom_range(1, 2) == 1) begin
         it.depth = 16'($urandom_range(0, 3));
      end
      case ($urandom_range(1, 20))
         1, 2, 3: begin
            it.allele_freq = 16'(32768 + $urandom_range(0, 8) - 4);
         end
         4, 5, 6: begin
         end
         default: begin
            if (band_floor < 16'h8000) begin
               it.allele_freq = 16'($urandom_range(int'(band_floor) + 1,
                                                   65535 - int'(band_floor)));
            end
         end
      endcase
      if ($urandom_range(1, finalize_odds) == 1) begin
         it.command = tkvs_pkg::CMD_FINALIZE;
      end
      return it;
   endfunction

   task automatic run_phase(input logic [31:0] base, input logic [31:0] threshold,
                            input int count, input int gap_odds);
      int n;
      wait_drained();
      configure(base, threshold);
      for (n = 0; n < count; n++) begin
         if (n == count / 2) begin
            wait_drained();
         end
         maybe_pause(gap_odds);
         send_item(random_item(14));
      end
      finalize();
   endtask

   task automatic test_empty_finalize();
      finalize();
   endtask

   task automatic test_band_edges();
      offer(5, tkvs_pkg::KIND_SNV, 0, 10, 3277);
      offer(6, tkvs_pkg::KIND_INS, 1, 11, 3278);
      offer(7, tkvs_pkg::KIND_DEL, 2, 12, 62259);
      offer(8, tkvs_pkg::KIND_DEL, 3, 13, 62258);
      offer(9, tkvs_pkg::KIND_NONE, 4, 14, 32768);
      offer(1023, tkvs_pkg::KIND_SNV, 15, 65535, 32768);
      finalize();
   endtask

   task automatic test_eviction_and_ties();
      wait_drained();
      configure(32'hFFFF_FF00, 32'(tkvs_pkg::THRESHOLD_RESET));
      offer(1023, tkvs_pkg::KIND_SNV, 2, 100, 32768);
      offer(0, tkvs_pkg::KIND_DEL, 9, 5, 3278);
      offer(0, tkvs_pkg::KIND_DEL, 9, 5, 62258);
      offer(0, tkvs_pkg::KIND_INS, 3, 7, 40000);
      offer(255, tkvs_pkg::KIND_SNV, 0, 5, 3278);
      offer(256, tkvs_pkg::KIND_INS, 1, 1000, 30000);
      offer(1023, tkvs_pkg::KIND_SNV, 1, 65535, 32769);
      offer(512, tkvs_pkg::KIND_DEL, 4, 9, 20000);
      offer(600, tkvs_pkg::KIND_SNV, 0, 4, 3278);
      offer(700, tkvs_pkg::KIND_INS, 2, 5, 62258);
      finalize();
   endtask

   task automatic test_threshold_extremes();
      wait_drained();
      configure(32'h0000_1000, 32'd32768);
      offer(1, tkvs_pkg::KIND_SNV, 1, 1, 32768);
      finalize();
      wait_drained();
      configure(32'h0000_2000, 32'd0);
      offer(2, tkvs_pkg::KIND_INS, 5, 2, 1);
      offer(3, tkvs_pkg::KIND_DEL, 6, 3, 65535);
      offer(4, tkvs_pkg::KIND_SNV, 7, 4, 0);
      finalize();
   endtask

   task automatic test_random_traffic();
      run_phase(32'h0010_0000, 32'd3277, 60, 3);
      run_phase(32'hFFFF_FE00, 32'd0, 60, 0);
      run_phase($urandom, $urandom_range(0, 32768), 60, 2);
      run_phase(32'h7FFF_FFFF, 32'd32767, 40, 3);
      run_phase(32'hFFFF_FFFF, 32'd20000, 50, 4);
      run_phase(32'h0000_0400, 32'd3277, 30, 0);
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_finalize();
      test_band_edges();
      test_eviction_and_ties();
      test_threshold_extremes();
      test_random_traffic();
      wait_drained();

      $display("Sent %0d items with %0d finalize runs and %0d predicted evictions.",
               items_sent, finalize_runs, evictions);
      $display("Checked %0d emitted items under %0d register settings.",
               variants_seen, settings_used + 1);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/tkvs_pkg.sv
rtl/core/tkvs_cell.sv
rtl/core/top_k_variant_selector_top.sv
bench/top_k_variant_selector_top_tb.sv
